>>> hdl/isst_pkg.sv
package isst_pkg;

    // Fixed field widths
    localparam int KEY_W = 8;
    localparam int OP_W  = 2;

    // Default geometry
    localparam int UNIVERSE_DEF     = 256;
    localparam int CLUSTER_SIZE_DEF = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_MEMBER = 2'd1,
        OP_SUCC   = 2'd2
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;      // latch request, read its cluster
        logic launch2;      // latch second cluster address
        logic read2;        // read second cluster
        logic commit_eval;  // finish after first read
        logic commit_fin;   // finish after second read
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_second;  // operation needs another cluster word
        logic out_free;     // output register can take a result
    } status_t;

endpackage

>>> hdl/isst_if.sv
// Request channel: one operation on one key
interface isst_req_if;
    logic                       valid;
    logic                       ready;
    logic [isst_pkg::OP_W-1:0]  op;
    logic [isst_pkg::KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// Response channel: one result per request
interface isst_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [isst_pkg::KEY_W-1:0] value;

    modport source (output valid, output found, output value, input ready);
    modport sink   (input valid, input found, input value, output ready);
endinterface

>>> hdl/isst_ctrl.sv
module isst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  isst_pkg::status_t  status,
    output isst_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_READ2 = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.need_second)
                begin
                    cmd.launch2 = 1'b1;
                    state_next  = S_READ2;
                end
                else if (status.out_free)
                begin
                    cmd.commit_eval = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_READ2:
            begin
                cmd.read2  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.commit_fin = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/isst_dpath.sv
module isst_dpath
#(
    parameter int UNIVERSE     = isst_pkg::UNIVERSE_DEF,
    parameter int CLUSTER_SIZE = isst_pkg::CLUSTER_SIZE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [isst_pkg::OP_W-1:0]  in_op,
    input  logic [isst_pkg::KEY_W-1:0] in_key,
    input  isst_pkg::cmd_t             cmd,
    output isst_pkg::status_t          status,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_found,
    output logic [isst_pkg::KEY_W-1:0] out_value
);

    localparam int KEY_W    = isst_pkg::KEY_W;
    localparam int KEY_SPAN = 1 << KEY_W;
    localparam int EFF_U    = (UNIVERSE < KEY_SPAN) ? UNIVERSE : KEY_SPAN;
    localparam int NUM_CL   = (EFF_U + CLUSTER_SIZE - 1) / CLUSTER_SIZE;
    localparam int CL_W     = (NUM_CL > 1) ? $clog2(NUM_CL) : 1;
    localparam int OFF_W    = $clog2(CLUSTER_SIZE);

    // Lowest set bit of a cluster word: {hit, offset}
    function automatic logic [OFF_W:0] first_bit(input logic [CLUSTER_SIZE-1:0] w);
        logic             hit;
        logic [OFF_W-1:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int i = CLUSTER_SIZE - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                hit = 1'b1;
                idx = OFF_W'(i);
            end
        end
        return {hit, idx};
    endfunction

    // Lowest set bit of the summary: {hit, cluster}
    function automatic logic [CL_W:0] first_cl(input logic [NUM_CL-1:0] w);
        logic            hit;
        logic [CL_W-1:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int i = NUM_CL - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                hit = 1'b1;
                idx = CL_W'(i);
            end
        end
        return {hit, idx};
    endfunction

    function automatic logic [CL_W-1:0] cl_of(input logic [KEY_W-1:0] k);
        return CL_W'(k / CLUSTER_SIZE);
    endfunction

    function automatic logic [OFF_W-1:0] off_of(input logic [KEY_W-1:0] k);
        return OFF_W'(k % CLUSTER_SIZE);
    endfunction

    function automatic logic [KEY_W-1:0] join_key(input logic [CL_W-1:0] c,
                                                  input logic [OFF_W-1:0] o);
        return KEY_W'(32'(c) * CLUSTER_SIZE + 32'(o));
    endfunction

    // Request and set registers
    logic [isst_pkg::OP_W-1:0] op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [KEY_W-1:0]          min_reg;
    logic [KEY_W-1:0]          max_reg;
    logic                      empty_reg;
    logic [NUM_CL-1:0]         sum_reg;
    logic [CL_W-1:0]           addr2_reg;
    logic [OFF_W-1:0]          xoff_reg;

    // Cluster memory and its per-entry valid bits
    logic [CLUSTER_SIZE-1:0]   mem [NUM_CL];
    logic [NUM_CL-1:0]         vld_reg;
    logic [CLUSTER_SIZE-1:0]   rd_word_reg;
    logic                      rd_vld_reg;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [KEY_W-1:0]          out_value_reg;

    logic                      rd_en;
    logic [CL_W-1:0]           rd_addr;
    logic                      wr_en;
    logic [CLUSTER_SIZE-1:0]   wr_word;
    logic [CLUSTER_SIZE-1:0]   word;

    logic                      in_rng;
    logic                      in_rng_new;
    logic [CL_W-1:0]           h;
    logic [OFF_W-1:0]          off;
    logic                      is_mem;
    logic [CLUSTER_SIZE-1:0]   above;
    logic [NUM_CL-1:0]         sum_above;
    logic [OFF_W:0]            ffs_h;
    logic [CL_W:0]             ffs_s;
    logic [OFF_W:0]            ffs_w;
    logic                      k_lt_min;
    logic [KEY_W-1:0]          x;
    logic                      load;
    logic                      need_second;
    logic                      res_found;
    logic [KEY_W-1:0]          res_value;

    // Cluster memory port
    assign in_rng_new = 32'(in_key) < UNIVERSE;
    assign rd_en      = cmd.capture | cmd.read2;
    assign rd_addr    = cmd.capture ? (in_rng_new ? cl_of(in_key) : '0) : addr2_reg;
    assign wr_en      = cmd.commit_fin && (op_reg == isst_pkg::OP_INSERT);
    assign wr_word    = word | ({{(CLUSTER_SIZE-1){1'b0}}, 1'b1} << xoff_reg);
    assign word       = rd_vld_reg ? rd_word_reg : '0;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[addr2_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[addr2_reg] <= 1'b1;
            end
        end
    end

    // Decode of the held request
    assign in_rng   = 32'(key_reg) < UNIVERSE;
    assign h        = cl_of(key_reg);
    assign off      = off_of(key_reg);
    assign is_mem   = in_rng && !empty_reg &&
                      ((key_reg == min_reg) || (key_reg == max_reg) || word[off]);
    assign k_lt_min = key_reg < min_reg;
    assign x        = k_lt_min ? min_reg : key_reg;

    // Successor searches: rest of own cluster, then summary, then found cluster
    always_comb
    begin
        for (int i = 0; i < CLUSTER_SIZE; i++)
        begin
            above[i] = word[i] && (i > int'(off));
        end
        for (int c = 0; c < NUM_CL; c++)
        begin
            sum_above[c] = sum_reg[c] && (c > int'(h));
        end
    end

    assign ffs_h = first_bit(above);
    assign ffs_s = first_cl(sum_above);
    assign ffs_w = first_bit(word);

    // Second cluster needed?
    always_comb
    begin
        case (op_reg)
            isst_pkg::OP_INSERT:
                need_second = in_rng && !empty_reg && !is_mem;
            isst_pkg::OP_SUCC:
                need_second = in_rng && !empty_reg && !k_lt_min &&
                              (key_reg < max_reg) && !ffs_h[OFF_W];
            default:
                need_second = 1'b0;
        endcase
    end

    assign status.need_second = need_second;
    assign status.out_free    = !out_valid_reg | out_ready;

    // Result for the finishing step
    always_comb
    begin
        res_found = 1'b0;
        res_value = key_reg;
        if (cmd.commit_fin)
        begin
            case (op_reg)
                isst_pkg::OP_INSERT:
                begin
                    res_found = 1'b1;
                end
                isst_pkg::OP_SUCC:
                begin
                    res_found = ffs_w[OFF_W];
                    if (ffs_w[OFF_W])
                    begin
                        res_value = join_key(addr2_reg, ffs_w[OFF_W-1:0]);
                    end
                end
                default:
                begin
                    res_found = 1'b0;
                end
            endcase
        end
        else
        begin
            case (op_reg)
                isst_pkg::OP_INSERT:
                begin
                    res_found = in_rng && empty_reg;
                end
                isst_pkg::OP_MEMBER:
                begin
                    res_found = is_mem;
                end
                isst_pkg::OP_SUCC:
                begin
                    if (in_rng && !empty_reg)
                    begin
                        if (k_lt_min)
                        begin
                            res_found = 1'b1;
                            res_value = min_reg;
                        end
                        else if ((key_reg < max_reg) && ffs_h[OFF_W])
                        begin
                            res_found = 1'b1;
                            res_value = join_key(h, ffs_h[OFF_W-1:0]);
                        end
                    end
                end
                default:
                begin
                    res_found = 1'b0;
                end
            endcase
        end
    end

    assign load = cmd.commit_eval | cmd.commit_fin;

    // Request capture and second address
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        if (cmd.launch2)
        begin
            addr2_reg <= (op_reg == isst_pkg::OP_INSERT) ? cl_of(x) : ffs_s[CL_W-1:0];
            xoff_reg  <= off_of(x);
        end
    end

    // Set state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            empty_reg <= 1'b1;
            sum_reg   <= '0;
        end
        else if (op_reg == isst_pkg::OP_INSERT)
        begin
            if (cmd.commit_eval && in_rng && empty_reg)
            begin
                min_reg   <= key_reg;
                max_reg   <= key_reg;
                empty_reg <= 1'b0;
            end
            if (cmd.commit_fin)
            begin
                if (k_lt_min)
                begin
                    min_reg <= key_reg;
                end
                if (x > max_reg)
                begin
                    max_reg <= x;
                end
                sum_reg[addr2_reg] <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_found_reg <= res_found;
            out_value_reg <= res_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_value = out_value_reg;

    // Set invariants and result checks
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (min_reg <= max_reg))
        else $error("set minimum above maximum");

    a_sum_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (|sum_reg) |-> !empty_reg)
        else $error("summary bit set in an empty set");

    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (op_reg == isst_pkg::OP_INSERT) && res_found) |=> !empty_reg)
        else $error("set still empty after insert");

    a_succ_greater: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (op_reg == isst_pkg::OP_SUCC) && res_found) |-> (res_value > key_reg))
        else $error("successor not above the key");

endmodule

>>> hdl/integer_set_successor_tree.sv
// Integer set with insert, membership and successor over a clustered bitmap.
// Lookups, duplicate inserts and successors inside the key's own cluster need one
// cluster read; a new insert into a non-empty set or a successor found through the
// summary needs a second one. A new request is taken only after the last result is
// loaded into the output register, which holds while its result is not accepted.
// Reset (async, active low) empties the set, summary and cluster valid bits at once.
module integer_set_successor_tree
#(
    parameter int UNIVERSE     = isst_pkg::UNIVERSE_DEF,
    parameter int CLUSTER_SIZE = isst_pkg::CLUSTER_SIZE_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    isst_req_if.sink   req,
    isst_rsp_if.source rsp
);

    isst_pkg::cmd_t    cmd;
    isst_pkg::status_t status;

    // Sequencer
    isst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Set storage and search logic
    isst_dpath
    #(
        .UNIVERSE     (UNIVERSE),
        .CLUSTER_SIZE (CLUSTER_SIZE)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (req.op),
        .in_key    (req.key),
        .cmd       (cmd),
        .status    (status),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_found (rsp.found),
        .out_value (rsp.value)
    );

endmodule

>>> test/integer_set_successor_tree_checker.sv
module integer_set_successor_tree_checker
    import isst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    isst_req_if  req,
    isst_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    localparam int NUM_CLUSTERS = (UNIVERSE_DEF + CLUSTER_SIZE_DEF - 1) / CLUSTER_SIZE_DEF;

    // Expected answer, with the request that caused it for the log
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             found;
        logic [KEY_W-1:0] value;
    } answer_t;

    answer_t answer_q[$];

    // Shadow copy of the set: min lives only in low_key, never in key_bits
    logic [UNIVERSE_DEF-1:0] key_bits      = '0;
    logic [NUM_CLUSTERS-1:0] busy_clusters = '0;
    int                      low_key       = 0;
    int                      high_key      = 0;
    bit                      set_is_empty  = 1'b1;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit holds_key(input int k);
        if (set_is_empty || k >= UNIVERSE_DEF)
            return 1'b0;
        return k == low_key || k == high_key || key_bits[k];
    endfunction

    // Lowest stored key in cluster c at offset lo or above
    function automatic bit first_in_cluster(input int c, input int lo, output int k);
        k = 0;
        for (int i = lo; i < CLUSTER_SIZE_DEF; i++)
        begin
            if (c * CLUSTER_SIZE_DEF + i >= UNIVERSE_DEF)
                return 1'b0;
            if (key_bits[c * CLUSTER_SIZE_DEF + i])
            begin
                k = c * CLUSTER_SIZE_DEF + i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit add_key(input int k);
        int x;
        x = k;
        if (k >= UNIVERSE_DEF)
            return 1'b0;
        if (set_is_empty)
        begin
            low_key      = k;
            high_key     = k;
            set_is_empty = 1'b0;
            return 1'b1;
        end
        if (holds_key(k))
            return 1'b0;
        // new minimum pushes the old one down into its cluster
        if (x < low_key)
        begin
            x       = low_key;
            low_key = k;
        end
        if (x > high_key)
            high_key = x;
        key_bits[x] = 1'b1;
        busy_clusters[x / CLUSTER_SIZE_DEF] = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit next_key(input int k, output int s);
        int h;
        s = 0;
        if (set_is_empty || k >= UNIVERSE_DEF)
            return 1'b0;
        if (k < low_key)
        begin
            s = low_key;
            return 1'b1;
        end
        if (k >= high_key)
            return 1'b0;
        // own cluster first, then the next non-empty one from the summary
        h = k / CLUSTER_SIZE_DEF;
        if (first_in_cluster(h, k % CLUSTER_SIZE_DEF + 1, s))
            return 1'b1;
        for (int c = h + 1; c < NUM_CLUSTERS; c++)
            if (busy_clusters[c])
                return first_in_cluster(c, 0, s);
        return 1'b0;
    endfunction

    function automatic answer_t predict_answer(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] key);
        answer_t a;
        int      s;
        a.op    = op;
        a.key   = key;
        a.found = 1'b0;
        a.value = key;
        s       = 0;
        case (op)
            OP_INSERT: a.found = add_key(key);
            OP_MEMBER: a.found = holds_key(key);
            OP_SUCC:
            begin
                a.found = next_key(key, s);
                if (a.found)
                    a.value = KEY_W'(s);
            end
            default: ;
        endcase
        return a;
    endfunction

    // Compare responses first: a request taken on this edge answers later
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                    note_mismatch($sformatf("response found=%0b value=%0d with no request open",
                                            rsp.found, rsp.value));
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.found !== want.found)
                        note_mismatch($sformatf("op=%0d key=%0d found=%0b, expected %0b",
                                                want.op, want.key, rsp.found, want.found));
                    if (rsp.value !== want.value)
                        note_mismatch($sformatf("op=%0d key=%0d value=%0d, expected %0d",
                                                want.op, want.key, rsp.value, want.value));
                end
            end
            if (req.valid && req.ready)
                answer_q.insert(answer_q.size(), predict_answer(req.op, req.key));
            pending <= answer_q.size();
        end
    end

endmodule

>>> test/integer_set_successor_tree_tb.sv
module integer_set_successor_tree_tb;

    import isst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE       = 10;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   ready_mode  = 0;
    int   mode_left   = 0;

    // keys sent as inserts, used to aim queries near stored keys
    bit   [UNIVERSE_DEF-1:0] inserted = '0;
    logic [KEY_W-1:0]        inserted_q[$];

    isst_req_if req_ch ();
    isst_rsp_if rsp_ch ();

    integer_set_successor_tree dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    integer_set_successor_tree_checker chk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Response stalls: switch between a few patterns every so often
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one request, in bursts with random gaps between them
    task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (op == OP_INSERT && !inserted[key])
        begin
            inserted[key] = 1'b1;
            inserted_q.insert(inserted_q.size(), key);
        end
    endtask

    initial
    begin
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               roll;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_INSERT;
        req_ch.key   = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty set: lookups, successor and undefined op
        send_req(OP_MEMBER, 8'd0);
        send_req(OP_SUCC,   8'd0);
        send_req(OP_SUCC,   8'd255);
        send_req(OP_UNDEF,  8'hAA);
        // single key, duplicate, successor below min and at max
        send_req(OP_INSERT, 8'd128);
        send_req(OP_INSERT, 8'd128);
        send_req(OP_MEMBER, 8'd128);
        send_req(OP_SUCC,   8'd127);
        send_req(OP_SUCC,   8'd128);
        // new max, then new min that pushes the old min into its cluster
        send_req(OP_INSERT, 8'd255);
        send_req(OP_INSERT, 8'd0);
        send_req(OP_MEMBER, 8'd0);
        send_req(OP_MEMBER, 8'd128);
        send_req(OP_MEMBER, 8'd255);
        send_req(OP_SUCC,   8'd0);
        send_req(OP_SUCC,   8'd128);
        send_req(OP_SUCC,   8'd254);
        send_req(OP_SUCC,   8'd255);
        // successor inside the key's own cluster, then a duplicate min, undefined ops, a miss
        send_req(OP_INSERT, 8'd129);
        send_req(OP_SUCC,   8'd128);
        send_req(OP_INSERT, 8'd0);
        send_req(OP_UNDEF,  8'h55);
        send_req(OP_UNDEF,  8'hFF);
        send_req(OP_MEMBER, 8'd17);

        // Random mix, inserts kept rare so the set fills slowly
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                op = OP_INSERT;
            else if (roll < 45)
                op = OP_MEMBER;
            else if (roll < 96)
                op = OP_SUCC;
            else
                op = OP_UNDEF;
            roll = $urandom_range(0, 3);
            if (roll < 2 || inserted_q.size() == 0)
                key = KEY_W'($urandom_range(0, UNIVERSE_DEF - 1));
            else if (roll == 2)
                key = KEY_W'($urandom_range(0, UNIVERSE_DEF / CLUSTER_SIZE_DEF - 1)
                             * CLUSTER_SIZE_DEF
                             + ($urandom_range(0, 1) ? CLUSTER_SIZE_DEF - 1 : 0));
            else
                key = inserted_q[$urandom_range(0, inserted_q.size() - 1)]
                      + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
            send_req(op, key);
        end
        req_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray response
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> integer_set_successor_tree.f
hdl/isst_pkg.sv
hdl/isst_if.sv
hdl/isst_ctrl.sv
hdl/isst_dpath.sv
hdl/integer_set_successor_tree.sv
test/integer_set_successor_tree_checker.sv
test/integer_set_successor_tree_tb.sv
